### hw/rtl/gbm_pkg.sv
`timescale 1ns / 1ps

package gbm_pkg;

  // Grid limits and derived storage sizes
  localparam int unsigned MaxCols = 64;
  localparam int unsigned MaxRows = 64;
  localparam int unsigned CellCnt = MaxCols * MaxRows;
  localparam int unsigned IdxW    = (CellCnt > 1) ? $clog2(CellCnt) : 1;

  // Field widths
  localparam int unsigned CoordW  = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned CntW    = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned EntryW  = CntW + SumW;

  // Configuration register indexes
  localparam logic RegGridCols = 1'b0;
  localparam logic RegGridRows = 1'b1;

  // Item modes
  localparam logic ModeAccum = 1'b0;
  localparam logic ModeRead  = 1'b1;

  // Divider status toward the controller
  typedef struct packed {
    logic            done;
    logic [CntW-1:0] quot;
  } div_res_t;

endpackage

### hw/rtl/gbm_ram.sv
`timescale 1ns / 1ps

module gbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/gbm_div.sv
`timescale 1ns / 1ps

module gbm_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [gbm_pkg::SumW-1:0] dividend_i,
  input  logic [gbm_pkg::CntW-1:0] divisor_i,
  output gbm_pkg::div_res_t       res_o
);
  import gbm_pkg::*;

  localparam int unsigned StepW = $clog2(CntW + 1);

  logic [StepW-1:0] step_q, step_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dvd_q, dvd_d;
  logic [CntW-1:0]  dsr_q, dsr_d;
  logic [CntW:0]    trial;
  logic [CntW:0]    diff;
  logic             ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[CntW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    step_d = step_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      // Quotient fits the count width, so the upper half is already below the divisor
      step_d = StepW'(CntW);
      rem_d  = dividend_i[SumW-1 -: CntW];
      dvd_d  = dividend_i[CntW-1:0];
      dsr_d  = divisor_i;
    end else if (step_q != '0) begin
      step_d = step_q - 1'b1;
      rem_d  = ge ? diff[CntW-1:0] : trial[CntW-1:0];
      dvd_d  = {dvd_q[CntW-2:0], ge};
      done_d = (step_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = dvd_q;

endmodule

### hw/rtl/grid_box_mean_binning.sv
`timescale 1ns / 1ps

// Grid box mean binning.
// Command channel: an item is taken at a clock edge with start_i high and busy_o
// low. Mode accumulate adds a point to the cell at (col_i, row_i); mode read
// returns the mean and count of the named cell on mean_o / count_o /
// empty_res_o / bad_cell_o, marked by valid_o for one cycle, then clears it.
// Results cannot be held off; each word is on the ports for exactly one cycle.
// Cells live in one 4096 x 48 bit single-read memory (count and sum per cell).
// Steps per item; busy_o is high while an item is in the read or divide state:
//   dropped point or read of a cell outside the grid: no memory access; the
//     bad-cell word is on the ports in the cycle right after the accepting edge;
//   accumulated point: memory read, then write back;
//   read of an empty cell: memory read, then write back; the word follows it;
//   read of a filled cell: memory read and write back, then the bit-serial
//     divider that produces one quotient bit per cycle for 16 bits; the word
//     follows its done flag.
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) is for the user to write only
// while idle; the block itself does not enforce it.
// After reset a clearing pass zeroes all 4096 cells, one per cycle, with
// busy_o high; configuration writes are taken during that pass.

module grid_box_mean_binning (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [gbm_pkg::CfgW-1:0]       cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic signed [gbm_pkg::CoordW-1:0]  col_i,
  input  logic signed [gbm_pkg::CoordW-1:0]  row_i,
  input  logic signed [gbm_pkg::SampleW-1:0] sample_i,
  input  logic                          col_missing_i,
  input  logic                          row_missing_i,
  input  logic                          sample_missing_i,
  output logic                          valid_o,
  output logic signed [gbm_pkg::SampleW-1:0] mean_o,
  output logic [gbm_pkg::CntW-1:0]       count_o,
  output logic                          empty_res_o,
  output logic                          bad_cell_o
);
  import gbm_pkg::*;

  localparam logic [1:0] StClear = 2'd0;
  localparam logic [1:0] StIdle  = 2'd1;
  localparam logic [1:0] StRead  = 2'd2;
  localparam logic [1:0] StDiv   = 2'd3;

  localparam logic [CfgW-1:0] MaxColsV = CfgW'(MaxCols);
  localparam logic [CfgW-1:0] MaxRowsV = CfgW'(MaxRows);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(CellCnt - 1);
  localparam int unsigned     ProdW    = CfgW + CfgW;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [CfgW-1:0] cols_q, rows_q;

  logic                      mode_q;
  logic [IdxW-1:0]           idx_q;
  logic signed [SampleW-1:0] smp_q;
  logic [CntW-1:0]           cnt_hold_q, cnt_hold_d;
  logic                      neg_q, neg_d;

  logic                      valid_q, valid_d;
  logic signed [SampleW-1:0] mean_q, mean_d;
  logic [CntW-1:0]           count_q, count_d;
  logic                      empty_q, empty_d;
  logic                      bad_q, bad_d;

  logic [CfgW-1:0]   nc, nr;
  logic [CfgW-1:0]   c7, r7;
  logic              col_ok, row_ok, in_grid;
  logic [ProdW-1:0]  idx_full;
  logic [IdxW-1:0]   idx_d;
  logic              accept;
  logic              load;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic [CntW-1:0]   rd_cnt;
  logic [SumW-1:0]   rd_sum;
  logic [SumW-1:0]   abs_sum;
  logic              div_start;
  div_res_t          div_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= MaxColsV;
      rows_q <= MaxRowsV;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegGridCols: cols_q <= cfg_wdata_i;
        RegGridRows: rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Locate the cell: clamp grid size, check bounds, form the linear index
  assign nc = (cols_q > MaxColsV) ? MaxColsV : cols_q;
  assign nr = (rows_q > MaxRowsV) ? MaxRowsV : rows_q;
  assign c7 = col_i[CfgW-1:0];
  assign r7 = row_i[CfgW-1:0];
  assign col_ok = !col_i[CoordW-1] && (c7 != '0) && (c7 <= nc) && !col_missing_i;
  assign row_ok = !row_i[CoordW-1] && (r7 != '0) && (r7 <= nr) && !row_missing_i;
  assign in_grid = col_ok && row_ok;
  assign idx_full = ProdW'(r7 - 1'b1) * ProdW'(nc) + ProdW'(c7 - 1'b1);
  assign idx_d    = idx_full[IdxW-1:0];

  assign accept = start_i && !busy_o;
  assign load   = accept && in_grid && ((mode_i == ModeRead) || !sample_missing_i);

  // Split the stored entry
  assign rd_cnt  = ram_rdata[EntryW-1 -: CntW];
  assign rd_sum  = ram_rdata[SumW-1:0];
  assign abs_sum = rd_sum[SumW-1] ? (SumW'(0) - rd_sum) : rd_sum;

  // Sequencer, memory write port and result words
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cnt_hold_d = cnt_hold_q;
    neg_d      = neg_q;
    valid_d    = 1'b0;
    mean_d     = mean_q;
    count_d    = count_q;
    empty_d    = empty_q;
    bad_d      = bad_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LastIdx) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept && (mode_i == ModeRead) && !in_grid) begin
          // Answer a read outside the grid at once
          valid_d = 1'b1;
          mean_d  = '0;
          count_d = '0;
          empty_d = 1'b1;
          bad_d   = 1'b1;
        end else if (load) begin
          ram_re  = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        if (mode_q == ModeAccum) begin
          // Drop the point when the count is saturated
          ram_we    = (rd_cnt != '1);
          ram_wdata = {rd_cnt + 1'b1,
                       rd_sum + {{(SumW-SampleW){smp_q[SampleW-1]}}, smp_q}};
          state_d   = StIdle;
        end else begin
          ram_we = 1'b1;
          if (rd_cnt == '0) begin
            valid_d = 1'b1;
            mean_d  = '0;
            count_d = '0;
            empty_d = 1'b1;
            bad_d   = 1'b0;
            state_d = StIdle;
          end else begin
            div_start  = 1'b1;
            cnt_hold_d = rd_cnt;
            neg_d      = rd_sum[SumW-1];
            state_d    = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_res.done) begin
          valid_d = 1'b1;
          mean_d  = neg_q ? (SampleW'(0) - div_res.quot) : div_res.quot;
          count_d = cnt_hold_q;
          empty_d = 1'b0;
          bad_d   = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
    end
  end

  // Hold item fields and result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      mode_q <= mode_i;
      idx_q  <= idx_d;
      smp_q  <= sample_i;
    end
    cnt_hold_q <= cnt_hold_d;
    neg_q      <= neg_d;
    mean_q     <= mean_d;
    count_q    <= count_d;
    empty_q    <= empty_d;
    bad_q      <= bad_d;
  end

  gbm_ram #(
    .Width (EntryW),
    .Depth (CellCnt)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  gbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (abs_sum),
    .divisor_i  (rd_cnt),
    .res_o      (div_res)
  );

  assign busy_o      = (state_q != StIdle);
  assign valid_o     = valid_q;
  assign mean_o      = mean_q;
  assign count_o     = count_q;
  assign empty_res_o = empty_q;
  assign bad_cell_o  = bad_q;

  // No result word while cells are being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !valid_o)
    else $error("result word during clearing pass");

  // The memory is written only by the sequencer outside idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != StIdle))
    else $error("memory write while idle");

  // The divider finishes only while a read waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == StDiv))
    else $error("divider done outside divide state");

  // A started divide always ends in a filled-cell result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && div_res.done) |=> (valid_o && !empty_res_o && !bad_cell_o))
    else $error("divide did not produce a result word");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import gbm_pkg::*;

  // Quiet cycles allowed; covers the clearing pass after reset several times over
  localparam int unsigned QuietLimit   = 20000;
  // Cycles to let pass after the last word before touching the grid size
  localparam int unsigned SettleCycles = 24;

  typedef struct {
    logic                      mode;
    logic signed [CoordW-1:0]  col;
    logic signed [CoordW-1:0]  row;
    logic signed [SampleW-1:0] sample;
    logic                      col_missing;
    logic                      row_missing;
    logic                      sample_missing;
  } bin_cmd_t;

  typedef struct {
    logic signed [SampleW-1:0] mean;
    logic [CntW-1:0]           count;
    logic                      empty_res;
    logic                      bad_cell;
  } bin_word_t;

  // Track cell counts and sums, and queue the cell words that reads must return
  class cell_mean_tracker;
    logic [CntW-1:0]        cell_cnt [CellCnt];
    logic signed [SumW-1:0] cell_acc [CellCnt];
    logic [CfgW-1:0]        cols_reg;
    logic [CfgW-1:0]        rows_reg;
    bin_word_t              mean_q [$];
    int                     errors;

    function new();
      cols_reg = 7'd64;
      rows_reg = 7'd64;
      errors   = 0;
      foreach (cell_cnt[i]) begin
        cell_cnt[i] = '0;
        cell_acc[i] = '0;
      end
    endfunction

    function void set_reg(logic idx, logic [CfgW-1:0] val);
      if (idx == RegGridCols) begin
        cols_reg = val;
      end else begin
        rows_reg = val;
      end
    endfunction

    // Clamp the grid size to the storage limits
    function int cols_eff();
      return (cols_reg > MaxCols) ? int'(MaxCols) : int'(cols_reg);
    endfunction

    function int rows_eff();
      return (rows_reg > MaxRows) ? int'(MaxRows) : int'(rows_reg);
    endfunction

    // Map a one-based coordinate pair to a cell, row-major with the columns in use
    function bit find_cell(bin_cmd_t cmd, output int idx);
      int c;
      int r;
      int nc;
      int nr;
      c   = cmd.col;
      r   = cmd.row;
      nc  = cols_eff();
      nr  = rows_eff();
      idx = 0;
      if (cmd.col_missing || cmd.row_missing) return 1'b0;
      if (c < 1 || r < 1 || c > nc || r > nr) return 1'b0;
      idx = (r - 1) * nc + (c - 1);
      return idx < int'(CellCnt);
    endfunction

    // Apply one accepted command word; reads queue the word they must return
    function void note_cmd(bin_cmd_t cmd);
      int        idx;
      int        quo;
      bit        in_grid;
      bin_word_t w;
      in_grid = find_cell(cmd, idx);
      if (cmd.mode == ModeAccum) begin
        // Drop missing, outside and saturated points
        if (in_grid && !cmd.sample_missing && cell_cnt[idx] != '1) begin
          cell_cnt[idx] = cell_cnt[idx] + 1'b1;
          cell_acc[idx] = cell_acc[idx] + cmd.sample;
        end
        return;
      end
      w.mean      = '0;
      w.count     = '0;
      w.empty_res = 1'b1;
      w.bad_cell  = 1'b1;
      if (in_grid) begin
        w.bad_cell  = 1'b0;
        w.count     = cell_cnt[idx];
        w.empty_res = (cell_cnt[idx] == 0);
        if (cell_cnt[idx] != 0) begin
          quo    = int'(cell_acc[idx]) / int'(cell_cnt[idx]);
          w.mean = quo[SampleW-1:0];
        end
        cell_cnt[idx] = '0;
        cell_acc[idx] = '0;
      end
      mean_q.push_back(w);
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compare a returned word with the oldest outstanding read
    task check_word(bin_word_t got);
      bin_word_t want;
      if (mean_q.size() == 0) begin
        report($sformatf("unexpected word mean %0d count %0d empty %0b bad %0b",
                         got.mean, got.count, got.empty_res, got.bad_cell));
        return;
      end
      want = mean_q.pop_front();
      if (got.mean !== want.mean)
        report($sformatf("mean %0d, want %0d", got.mean, want.mean));
      if (got.count !== want.count)
        report($sformatf("count %0d, want %0d", got.count, want.count));
      if (got.empty_res !== want.empty_res)
        report($sformatf("empty_res %0b, want %0b", got.empty_res, want.empty_res));
      if (got.bad_cell !== want.bad_cell)
        report($sformatf("bad_cell %0b, want %0b", got.bad_cell, want.bad_cell));
    endtask

    function int pending();
      return mean_q.size();
    endfunction
  endclass

  logic                      clk_i            = 1'b0;
  logic                      rst_ni           = 1'b0;
  logic                      cfg_we_i         = 1'b0;
  logic                      cfg_idx_i        = 1'b0;
  logic [CfgW-1:0]           cfg_wdata_i      = '0;
  logic                      start_i          = 1'b0;
  logic                      busy_o;
  logic                      mode_i           = 1'b0;
  logic signed [CoordW-1:0]  col_i            = '0;
  logic signed [CoordW-1:0]  row_i            = '0;
  logic signed [SampleW-1:0] sample_i         = '0;
  logic                      col_missing_i    = 1'b0;
  logic                      row_missing_i    = 1'b0;
  logic                      sample_missing_i = 1'b0;
  logic                      valid_o;
  logic signed [SampleW-1:0] mean_o;
  logic [CntW-1:0]           count_o;
  logic                      empty_res_o;
  logic                      bad_cell_o;

  cell_mean_tracker cells = new();
  bit               idling_on = 1'b1;
  int unsigned      quiet_cycles = 0;

  grid_box_mean_binning dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .mode_i           (mode_i),
    .col_i            (col_i),
    .row_i            (row_i),
    .sample_i         (sample_i),
    .col_missing_i    (col_missing_i),
    .row_missing_i    (row_missing_i),
    .sample_missing_i (sample_missing_i),
    .valid_o          (valid_o),
    .mean_o           (mean_o),
    .count_o          (count_o),
    .empty_res_o      (empty_res_o),
    .bad_cell_o       (bad_cell_o)
  );

  always #5 clk_i = ~clk_i;

  // Take every cell word on its strobe cycle
  always @(posedge clk_i) begin : take_word
    bin_word_t got;
    if (rst_ni && valid_o === 1'b1) begin
      got.mean      = mean_o;
      got.count     = count_o;
      got.empty_res = empty_res_o;
      got.bad_cell  = bad_cell_o;
      cells.check_word(got);
    end
  end

  // Stop a run in which no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni && ((start_i && busy_o === 1'b0) || valid_o === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bin_cmd_t make_cmd(logic mode, int c, int r, int s,
                                        bit cm, bit rm, bit sm);
    bin_cmd_t cmd;
    cmd.mode           = mode;
    cmd.col            = c[CoordW-1:0];
    cmd.row            = r[CoordW-1:0];
    cmd.sample         = s[SampleW-1:0];
    cmd.col_missing    = cm;
    cmd.row_missing    = rm;
    cmd.sample_missing = sm;
    return cmd;
  endfunction

  // Favor a few corner cells so that reads find filled cells
  function automatic logic signed [CoordW-1:0] pick_coord(int n);
    int k;
    k = $urandom_range(0, 99);
    if (n == 0) return CoordW'($urandom_range(0, 2));
    if (k < 55) return CoordW'($urandom_range(1, (n < 3) ? n : 3));
    if (k < 70) return CoordW'(n + $urandom_range(0, 1));
    if (k < 85) return CoordW'($urandom_range(1, n));
    return CoordW'($urandom_range(0, 255));
  endfunction

  function automatic bin_cmd_t random_cmd();
    bin_cmd_t cmd;
    cmd.mode = ($urandom_range(0, 99) < 30) ? ModeRead : ModeAccum;
    cmd.col  = pick_coord(cells.cols_eff());
    cmd.row  = pick_coord(cells.rows_eff());
    case ($urandom_range(0, 9))
      0:       cmd.sample = 16'h7FFF;
      1:       cmd.sample = 16'h8000;
      2:       cmd.sample = '0;
      default: cmd.sample = SampleW'($urandom_range(0, 65535));
    endcase
    cmd.col_missing    = ($urandom_range(0, 99) < 8);
    cmd.row_missing    = ($urandom_range(0, 99) < 8);
    cmd.sample_missing = ($urandom_range(0, 99) < 8);
    return cmd;
  endfunction

  // Present one command word, idling now and then, and hold it until taken
  task automatic send_cmd(bin_cmd_t cmd);
    while (idling_on && $urandom_range(0, 99) < 30) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i          <= 1'b1;
    mode_i           <= cmd.mode;
    col_i            <= cmd.col;
    row_i            <= cmd.row;
    sample_i         <= cmd.sample;
    col_missing_i    <= cmd.col_missing;
    row_missing_i    <= cmd.row_missing;
    sample_missing_i <= cmd.sample_missing;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    cells.note_cmd(cmd);
  endtask

  // Hold off commands until every outstanding read has returned its word
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (cells.pending() != 0);
  endtask

  task automatic write_grid(logic [CfgW-1:0] ncols, logic [CfgW-1:0] nrows);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegGridCols;
    cfg_wdata_i <= ncols;
    @(posedge clk_i);
    cells.set_reg(RegGridCols, ncols);
    cfg_idx_i   <= RegGridRows;
    cfg_wdata_i <= nrows;
    @(posedge clk_i);
    cells.set_reg(RegGridRows, nrows);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    bin_cmd_t plan [$];
    int       phase_cols [9] = '{1, 7, 64, 1, 127, 0, 100, 64, 0};
    int       phase_rows [9] = '{1, 5, 1, 64, 127, 10, 3, 64, 0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Grid size is taken during the clearing pass
    write_grid(7'd64, 7'd64);

    // Directed: extremes, truncation, missing flags, outside cells, empty reads
    plan.push_back(make_cmd(ModeAccum, 1, 1, 32767, 0, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 1, 1, 32767, 0, 0, 0));
    plan.push_back(make_cmd(ModeRead, 1, 1, 0, 0, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 64, 64, -32768, 0, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 64, 64, 1, 0, 0, 0));
    plan.push_back(make_cmd(ModeRead, 64, 64, -1, 0, 0, 1));
    plan.push_back(make_cmd(ModeRead, 64, 64, 0, 0, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 2, 2, 100, 1, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 2, 2, 100, 0, 1, 0));
    plan.push_back(make_cmd(ModeAccum, 2, 2, 100, 0, 0, 1));
    plan.push_back(make_cmd(ModeAccum, 2, 2, -7, 0, 0, 0));
    plan.push_back(make_cmd(ModeRead, 2, 2, 0, 0, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 0, 1, 5, 0, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 65, 1, 5, 0, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 1, -128, 5, 0, 0, 0));
    plan.push_back(make_cmd(ModeAccum, 127, 127, 5, 0, 0, 0));
    plan.push_back(make_cmd(ModeRead, 65, 1, 0, 0, 0, 0));
    plan.push_back(make_cmd(ModeRead, 0, 1, 0, 0, 0, 0));
    plan.push_back(make_cmd(ModeRead, 1, -1, 0, 0, 0, 0));
    plan.push_back(make_cmd(ModeRead, 1, 1, 0, 1, 0, 0));
    plan.push_back(make_cmd(ModeRead, 1, 1, 0, 0, 1, 0));
    plan.push_back(make_cmd(ModeRead, 1, 1, 0, 0, 0, 0));
    foreach (plan[i]) send_cmd(plan[i]);
    drain();

    // Random phases over several grid sizes, the last one random
    phase_cols[8] = $urandom_range(1, 127);
    phase_rows[8] = $urandom_range(1, 127);
    for (int p = 0; p < 9; p++) begin
      drain();
      repeat (SettleCycles) @(posedge clk_i);
      write_grid(phase_cols[p][CfgW-1:0], phase_rows[p][CfgW-1:0]);
      idling_on = (p != 2);
      for (int n = 0; n < 180; n++) begin
        if ($urandom_range(0, 99) < 3) drain();
        send_cmd(random_cmd());
      end
    end

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (cells.errors == 0 && cells.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
